[src/st2d_pkg.sv]
// shared types, constants and helpers for the 2d sparse table range query block
// no dependencies

package st2d_pkg;

    localparam int DEF_MAX_ROWS   = 32;
    localparam int DEF_MAX_COLS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int FIELD_BITS = 5;
    localparam int DIM_BITS   = 6;
    localparam int CFG_BITS   = 6;
    localparam int OUT_BITS   = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_MAX  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the input beat
        logic rd_issue;   // present read address
        logic acc_first;  // load accumulator with read data
        logic acc_merge;  // merge read data into accumulator
        logic wr_load;    // write load value
        logic wr_acc;     // write accumulator to build target
        logic step_pass;  // advance build counters
        logic [1:0] sel;  // which of four reads
        logic out_load;   // latch result
    } st2d_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       bad_query;
        logic       load_ok;
        logic       build_done;
        logic       build_skip;  // current build slot has nothing to do
        logic [1:0] build_reads; // reads - 1 for current build slot
    } st2d_sts_t;

    // floor log2 of a small count
    function automatic logic [3:0] flog2(input logic [8:0] n);
        logic [3:0] k;
        k = '0;
        for (int b = 1; b < 9; b++) begin
            if (n[b]) k = 4'(b);
        end
        return k;
    endfunction

endpackage

[src/st2d_datapath.sv]
// datapath: input capture, table memory, address generation, build counters, merge
// depends on st2d_pkg

module st2d_datapath import st2d_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  st2d_cmd_t              cmd,
    output st2d_sts_t              sts,
    input  logic [1:0]             s_operation,
    input  logic [FIELD_BITS-1:0]  s_row,
    input  logic [FIELD_BITS-1:0]  s_col,
    input  logic [FIELD_BITS-1:0]  s_row_end,
    input  logic [FIELD_BITS-1:0]  s_col_end,
    input  logic signed [31:0]     s_value,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data,
    output logic signed [OUT_BITS-1:0] res_answer,
    output logic                   res_error
);

    localparam int RL   = $clog2(MAX_ROWS) + 1;
    localparam int CL   = $clog2(MAX_COLS) + 1;
    localparam int RB   = $clog2(MAX_ROWS);
    localparam int CB   = $clog2(MAX_COLS);
    localparam int XB   = $clog2(RL);
    localparam int YB   = $clog2(CL);
    localparam int DEPTH = MAX_ROWS * MAX_COLS * RL * CL;
    localparam int AB   = $clog2(DEPTH);
    localparam int NB   = RB + 1;
    localparam int MB   = CB + 1;

    // configuration registers
    logic [CFG_BITS-1:0] rows_reg, cols_reg;
    logic                max_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_BITS'(32);
            cols_reg <= CFG_BITS'(32);
            max_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                CFG_MAX:  max_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturated sizes in use
    logic [NB-1:0] n_eff;
    logic [MB-1:0] m_eff;
    always_comb begin
        if (rows_reg == '0) n_eff = NB'(1);
        else if (32'(rows_reg) > MAX_ROWS) n_eff = NB'(MAX_ROWS);
        else n_eff = NB'(rows_reg);
        if (cols_reg == '0) m_eff = MB'(1);
        else if (32'(cols_reg) > MAX_COLS) m_eff = MB'(MAX_COLS);
        else m_eff = MB'(cols_reg);
    end

    // captured beat
    logic [1:0]            op_reg;
    logic [FIELD_BITS-1:0] r1_reg, c1_reg, r2_reg, c2_reg;
    logic [VALUE_BITS-1:0] val_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_operation;
            r1_reg  <= s_row;
            c1_reg  <= s_col;
            r2_reg  <= s_row_end;
            c2_reg  <= s_col_end;
            val_reg <= VALUE_BITS'(s_value);
        end
    end

    // query geometry
    logic [3:0] qx, qy;
    logic [FIELD_BITS-1:0] r3, c3;
    always_comb begin
        qx = flog2(9'(r2_reg - r1_reg) + 9'd1);
        qy = flog2(9'(c2_reg - c1_reg) + 9'd1);
        r3 = FIELD_BITS'(9'(r2_reg) + 9'd1 - (9'd1 << qx));
        c3 = FIELD_BITS'(9'(c2_reg) + 9'd1 - (9'd1 << qy));
    end

    assign sts.op = op_reg;
    assign sts.bad_query = (r1_reg > r2_reg) || (c1_reg > c2_reg) ||
                           (9'(r2_reg) >= 9'(n_eff)) || (9'(c2_reg) >= 9'(m_eff));
    assign sts.load_ok = (32'(r1_reg) < MAX_ROWS) && (32'(c1_reg) < MAX_COLS);

    // build walk: pass 0 rows (x=0,y>0), pass 1 cols (y=0,x>0), pass 2 both
    logic [1:0]  pass_reg;
    logic [3:0]  bx_reg, by_reg;
    logic [NB-1:0] bi_reg;
    logic [MB-1:0] bj_reg;
    logic [3:0]  ln, lm;
    assign ln = flog2(9'(n_eff));
    assign lm = flog2(9'(m_eff));

    logic pass_empty, slot_fits;
    always_comb begin
        case (pass_reg)
            2'd0:    pass_empty = (lm == 4'd0);
            2'd1:    pass_empty = (ln == 4'd0);
            default: pass_empty = (ln == 4'd0) || (lm == 4'd0);
        endcase
        slot_fits = (10'(bi_reg) + (10'd1 << bx_reg) <= 10'(n_eff)) &&
                    (10'(bj_reg) + (10'd1 << by_reg) <= 10'(m_eff));
    end
    assign sts.build_done  = (pass_reg == 2'd3);
    assign sts.build_skip  = pass_empty || !slot_fits;
    assign sts.build_reads = (pass_reg == 2'd2) ? 2'd3 : 2'd1;

    // build counters: scan bi, bj over full range, levels per pass order
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pass_reg <= 2'd0;
            bx_reg   <= 4'd0;
            by_reg   <= 4'd1;
            bi_reg   <= '0;
            bj_reg   <= '0;
        end else if (cmd.step_pass) begin
            if (pass_empty) begin
                pass_reg <= pass_reg + 2'd1;
                bi_reg <= '0; bj_reg <= '0;
                bx_reg <= (pass_reg == 2'd0) ? 4'd1 : 4'd1;
                by_reg <= (pass_reg == 2'd0) ? 4'd0 : 4'd1;
            end else begin
                case (pass_reg)
                    2'd0: begin
                        // i, y, j
                        if (10'(bj_reg) + 10'd1 < 10'(m_eff)) bj_reg <= bj_reg + 1'b1;
                        else begin
                            bj_reg <= '0;
                            if (by_reg < lm) by_reg <= by_reg + 4'd1;
                            else begin
                                by_reg <= 4'd1;
                                if (10'(bi_reg) + 10'd1 < 10'(n_eff)) bi_reg <= bi_reg + 1'b1;
                                else begin
                                    bi_reg <= '0; pass_reg <= 2'd1;
                                    bx_reg <= 4'd1; by_reg <= 4'd0;
                                end
                            end
                        end
                    end
                    2'd1: begin
                        // j, x, i
                        if (10'(bi_reg) + 10'd1 < 10'(n_eff)) bi_reg <= bi_reg + 1'b1;
                        else begin
                            bi_reg <= '0;
                            if (bx_reg < ln) bx_reg <= bx_reg + 4'd1;
                            else begin
                                bx_reg <= 4'd1;
                                if (10'(bj_reg) + 10'd1 < 10'(m_eff)) bj_reg <= bj_reg + 1'b1;
                                else begin
                                    bj_reg <= '0; pass_reg <= 2'd2;
                                    bx_reg <= 4'd1; by_reg <= 4'd1;
                                end
                            end
                        end
                    end
                    default: begin
                        // x, i, y, j
                        if (10'(bj_reg) + 10'd1 < 10'(m_eff)) bj_reg <= bj_reg + 1'b1;
                        else begin
                            bj_reg <= '0;
                            if (by_reg < lm) by_reg <= by_reg + 4'd1;
                            else begin
                                by_reg <= 4'd1;
                                if (10'(bi_reg) + 10'd1 < 10'(n_eff)) bi_reg <= bi_reg + 1'b1;
                                else begin
                                    bi_reg <= '0;
                                    if (bx_reg < ln) bx_reg <= bx_reg + 4'd1;
                                    else pass_reg <= 2'd3;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    function automatic logic [AB-1:0] slot(input logic [RB-1:0] r, input logic [CB-1:0] c,
                                           input logic [XB-1:0] x, input logic [YB-1:0] y);
        return AB'(((32'(r) * MAX_COLS + 32'(c)) * RL + 32'(x)) * CL + 32'(y));
    endfunction

    // read address selection
    logic [RB-1:0] ra_r;
    logic [CB-1:0] ra_c;
    logic [XB-1:0] ra_x;
    logic [YB-1:0] ra_y;
    logic [NB+4:0] hi;
    logic [MB+4:0] hj;
    always_comb begin
        hi = (NB+5)'(bi_reg) + ((NB+5)'(1) << (bx_reg - 4'd1));
        hj = (MB+5)'(bj_reg) + ((MB+5)'(1) << (by_reg - 4'd1));
        ra_r = RB'(r1_reg); ra_c = CB'(c1_reg); ra_x = XB'(qx); ra_y = YB'(qy);
        if (op_reg == OP_QUERY) begin
            if (cmd.sel[1]) ra_r = RB'(r3);
            if (cmd.sel[0]) ra_c = CB'(c3);
        end else begin
            ra_r = RB'(bi_reg); ra_c = CB'(bj_reg);
            case (pass_reg)
                2'd0: begin
                    ra_x = '0; ra_y = YB'(by_reg - 4'd1);
                    if (cmd.sel[0]) ra_c = CB'(hj);
                end
                2'd1: begin
                    ra_y = '0; ra_x = XB'(bx_reg - 4'd1);
                    if (cmd.sel[0]) ra_r = RB'(hi);
                end
                default: begin
                    ra_x = XB'(bx_reg - 4'd1); ra_y = YB'(by_reg - 4'd1);
                    if (cmd.sel[1]) ra_r = RB'(hi);
                    if (cmd.sel[0]) ra_c = CB'(hj);
                end
            endcase
        end
    end

    // table memory, one port read, one port write
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_reg;
    logic                  wr_en;
    logic [AB-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data, acc_reg;
    always_comb begin
        wr_en   = cmd.wr_load || cmd.wr_acc;
        wr_addr = cmd.wr_load ? slot(RB'(r1_reg), CB'(c1_reg), '0, '0)
                              : slot(RB'(bi_reg), CB'(bj_reg), XB'(bx_reg), YB'(by_reg));
        wr_data = cmd.wr_load ? val_reg : acc_reg;
    end
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_issue) rd_reg <= mem[slot(ra_r, ra_c, ra_x, ra_y)];
    end

    // min or max merge accumulator
    logic rd_less;
    assign rd_less = $signed(rd_reg) < $signed(acc_reg);
    always_ff @(posedge aclk) begin
        if (cmd.acc_first) acc_reg <= rd_reg;
        else if (cmd.acc_merge && (rd_less != max_reg) && (rd_reg != acc_reg))
            acc_reg <= rd_reg;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (op_reg == OP_QUERY && !sts.bad_query) begin
                res_answer <= OUT_BITS'($signed(acc_reg));
                res_error  <= 1'b0;
            end else begin
                res_answer <= '0;
                res_error  <= (op_reg == OP_QUERY) || (op_reg == 2'd3);
            end
        end
    end

endmodule

[src/st2d_ctrl.sv]
// controller state machine sequencing load, build and query items
// depends on st2d_pkg

module st2d_ctrl import st2d_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output st2d_cmd_t cmd,
    input  st2d_sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_BSLOT = 3'd3;
    localparam logic [2:0] ST_BWR   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;   // read issue index, one extra for the drain
    logic       mv_reg, mv_next;
    logic [1:0] last_rd;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign last_rd = (sts.op == OP_QUERY) ? 2'd3 : sts.build_reads;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.sel    = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                cnt_next = '0;
                case (sts.op)
                    OP_LOAD: begin
                        cmd.wr_load = sts.load_ok;
                        state_next  = ST_DONE;
                    end
                    OP_BUILD: state_next = ST_BSLOT;
                    OP_QUERY: state_next = sts.bad_query ? ST_DONE : ST_READ;
                    default:  state_next = ST_DONE;
                endcase
            end
            // reads issue on cnt 0..last, data merges from the read register in the next cycle
            ST_READ: begin
                cmd.rd_issue  = (cnt_reg[1:0] <= last_rd) && !cnt_reg[2];
                cmd.acc_first = (cnt_reg == 3'd1);
                cmd.acc_merge = (cnt_reg > 3'd1);
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg == 3'(last_rd) + 3'd1)
                    state_next = (sts.op == OP_QUERY) ? ST_DONE : ST_BWR;
            end
            ST_BSLOT: begin
                cnt_next = '0;
                if (sts.build_done) state_next = ST_DONE;
                else if (sts.build_skip) cmd.step_pass = 1'b1;
                else state_next = ST_READ;
            end
            ST_BWR: begin
                cmd.wr_acc    = 1'b1;
                cmd.step_pass = 1'b1;
                state_next    = ST_BSLOT;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

[src/sparse_table_2d_range_min.sv]
// 2d sparse table rectangle min/max query. One beat is in flight at a time. A load, a rejected
// query or an unknown operation passes through accept, decode and result. A good query passes
// through accept, decode, four reads through the single table memory port plus a drain of the
// read data, and result. A build adds the walk between decode and result. The walk visits every
// slot of every level in use. A slot that does not fit is only checked and skipped. A slot that
// fits is checked, then read two times (row-only or column-only level) or four times (combined
// level), then written. The result register lets the next beat enter while a result waits; an
// item stalls in its result state only while the previous result is still unaccepted. Query
// bounds are checked against rows_in_use/cols_in_use; reading unbuilt entries returns undefined
// data.
// depends on st2d_pkg, st2d_ctrl, st2d_datapath

module sparse_table_2d_range_min import st2d_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [FIELD_BITS-1:0]    s_row,
    input  logic [FIELD_BITS-1:0]    s_col,
    input  logic [FIELD_BITS-1:0]    s_row_end,
    input  logic [FIELD_BITS-1:0]    s_col_end,
    input  logic signed [31:0]       s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_BITS-1:0] m_answer,
    output logic                     m_error,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data
);

    st2d_cmd_t cmd;
    st2d_sts_t sts;

    st2d_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .sts
    );

    st2d_datapath #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .s_operation, .s_row, .s_col, .s_row_end, .s_col_end, .s_value,
        .cfg_wr_en, .cfg_index, .cfg_data,
        .res_answer(m_answer), .res_error(m_error)
    );

endmodule

[src/st2d_checker.sv]
// port level checks for the sparse table block
// depends on sparse_table_2d_range_min ports

module st2d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_answer,
    input logic        m_error
);

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_answer) && $stable(m_error))
        else $error("result changed under stall");

    // an error result carries a zero answer
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_answer == '0)
        else $error("error with nonzero answer");

    // no result right after accepting a beat
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    // busy after a beat is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two beats back to back");

endmodule

bind sparse_table_2d_range_min st2d_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_answer, .m_error
);
